// File: rtl/core/ewh_pkg.sv
package ewh_pkg;

    localparam int DEF_MAX_BINS   = 1024;
    localparam int DEF_COUNT_BITS = 32;

    localparam int SAMPLE_W   = 32;
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 32;
    localparam int REG_W      = 32;
    localparam int WIDTH_W    = 31;
    localparam int CCOUNT_W   = 11;
    localparam int CFG_IDX_W  = 2;

    localparam int S_FIELDS_W = SAMPLE_W + INDEX_W;
    localparam int S_TDATA_W  = 48;
    localparam int M_FIELDS_W = INDEX_W + 3 * VALUE_W;
    localparam int M_TDATA_W  = 112;

    localparam logic [REG_W-1:0]    RANGE_LOW_RST  = 32'd0;
    localparam logic [REG_W-1:0]    RANGE_HIGH_RST = 32'd3276800;
    localparam logic [WIDTH_W-1:0]  CELL_WIDTH_RST = 31'd65536;
    localparam logic [CCOUNT_W-1:0] CELL_COUNT_RST = 11'd50;

    localparam logic OP_COLLECT = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW  = 2'd0,
        CFG_RANGE_HIGH = 2'd1,
        CFG_CELL_WIDTH = 2'd2,
        CFG_CELL_COUNT = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        REGION_IN       = 2'd0,
        REGION_UNDER    = 2'd1,
        REGION_OVER     = 2'd2,
        REGION_BAD_READ = 2'd3
    } region_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

// File: rtl/core/ewh_div.sv
module ewh_div
    import ewh_pkg::*;
#(
    parameter int QB = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] dividend,
    input  logic [WIDTH_W-1:0]  divisor,
    output logic                done,
    output logic [QB-1:0]       quotient
);

    localparam int DW = SAMPLE_W + QB;
    localparam int CW = $clog2(QB + 1);

    logic          run_reg,  run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [DW-1:0] rem_reg,  rem_next;
    logic [DW-1:0] den_reg,  den_next;
    logic [QB-1:0] quo_reg,  quo_next;
    logic          fits;

    assign fits = (rem_reg >= den_reg);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(QB);
            rem_next = DW'(dividend);
            den_next = DW'(divisor) << (QB - 1);
            quo_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = fits ? (rem_reg - den_reg) : rem_reg;
            quo_next = (quo_reg << 1) | QB'(fits);
            den_next = den_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/ewh_mem.sv
module ewh_mem
    import ewh_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_BINS,
    parameter int AW    = $clog2(DEF_MAX_BINS),
    parameter int DW    = DEF_COUNT_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mem_cmd_t      cmd,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata,
    output logic          ready
);

    logic [DW-1:0] mem [DEPTH];

    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [DW-1:0] rdata_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    assign wr_en   = clearing_reg || cmd.wr;
    assign wr_addr = clearing_reg ? clr_addr_reg : addr;
    assign wr_data = clearing_reg ? '0 : wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clearing_reg;

endmodule

// File: rtl/core/equal_width_histogram_core.sv
// Equal-width histogram over signed Q16.16 samples, with underflow and
// overflow counters and saturating bin counters.
// Input stream: s_tuser is the op (0 collect a sample, 1 read a bin);
// s_tdata carries the sample and the read index. Output stream: one
// transfer per input transfer, m_tuser is the region code and m_tdata
// carries the bin index, bin value and both out-of-range totals.
// Configuration: cfg_we writes cfg_data into register cfg_index (range
// low, range high, cell width, cell count); write only while idle.
// Timing: one item at a time. A read passes through READ and EMIT to its
// result; an underflow sample through PREP and EMIT; a sample at or above
// range high, or beyond clog2(MAX_BINS) bits of bin index, through PREP,
// CHECK and EMIT; a sample past the last bin in use that the divider must
// place through PREP, CHECK, DIV and EMIT; a sample that needs its bin
// through PREP, CHECK, DIV, READ and EMIT, waiting in DIV on the
// one-bit-per-cycle divider, then reading and writing back the counter
// memory. The next input transfer is taken as soon as the result sits
// in the output register, even while m_tready is low; a stalled result
// holds until taken, and the block waits only when a second result is
// ready while the first still waits. Reset: all counters clear; the bin
// memory is swept to zero, with s_tready low until the sweep is done.
module equal_width_histogram_core
    import ewh_pkg::*;
#(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sample, read_index
    input  logic                 s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // bin_index, bin_value, under_total, over_total
    output logic [1:0]           m_tuser    // region
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int NB_W  = IDX_W + 1;
    localparam int DW    = SAMPLE_W + IDX_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_READ  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t                 state_reg,      state_next;
    logic                   out_valid_reg,  out_valid_next;
    logic [COUNT_BITS-1:0]  under_cnt_reg,  under_cnt_next;
    logic [COUNT_BITS-1:0]  over_cnt_reg,   over_cnt_next;
    logic signed [REG_W-1:0] range_low_reg,  range_low_next;
    logic signed [REG_W-1:0] range_high_reg, range_high_next;
    logic [WIDTH_W-1:0]     cell_width_reg, cell_width_next;
    logic [CCOUNT_W-1:0]    cell_count_reg, cell_count_next;

    logic                   op_reg,         op_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [SAMPLE_W-1:0]    diff_reg,       diff_next;
    logic                   above_reg,      above_next;
    logic                   bad_reg,        bad_next;
    logic [IDX_W-1:0]       idx_reg,        idx_next;
    region_t                res_region_reg, res_region_next;
    logic [COUNT_BITS-1:0]  res_value_reg,  res_value_next;
    logic [INDEX_W-1:0]     out_index_reg,  out_index_next;
    region_t                out_region_reg, out_region_next;
    logic [VALUE_W-1:0]     out_value_reg,  out_value_next;
    logic [VALUE_W-1:0]     out_under_reg,  out_under_next;
    logic [VALUE_W-1:0]     out_over_reg,   out_over_next;

    logic                   in_fire;
    logic [INDEX_W-1:0]     in_rindex;
    logic [NB_W-1:0]        nbins;
    logic [WIDTH_W-1:0]     w_eff;
    logic [SAMPLE_W:0]      diff_full;
    logic [DW-1:0]          span;
    logic                   big;
    logic                   out_free;
    logic [COUNT_BITS-1:0]  under_inc;
    logic [COUNT_BITS-1:0]  over_inc;
    logic [COUNT_BITS-1:0]  bin_inc;

    mem_cmd_t               mem_cmd;
    logic [IDX_W-1:0]       mem_addr;
    logic [COUNT_BITS-1:0]  mem_rdata;
    logic                   mem_ready;
    logic                   div_start;
    logic                   div_done;
    logic [IDX_W-1:0]       div_quot;

    ewh_div #(
        .QB (IDX_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_reg),
        .divisor  (w_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    ewh_mem #(
        .DEPTH (MAX_BINS),
        .AW    (IDX_W),
        .DW    (COUNT_BITS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (bin_inc),
        .rdata (mem_rdata),
        .ready (mem_ready)
    );

    assign s_tready  = (state_reg == ST_IDLE) && mem_ready;
    assign in_fire   = s_tvalid && s_tready;
    assign in_rindex = s_tdata[S_FIELDS_W-1:SAMPLE_W];
    assign out_free  = !out_valid_reg || m_tready;

    assign nbins = (int'(cell_count_reg) > MAX_BINS) ? NB_W'(MAX_BINS) : NB_W'(cell_count_reg);
    assign w_eff = (cell_width_reg == '0) ? WIDTH_W'(1) : cell_width_reg;

    assign diff_full = {sample_reg[SAMPLE_W-1], sample_reg}
                     - {range_low_reg[REG_W-1], range_low_reg};
    assign span      = DW'(w_eff) << IDX_W;
    assign big       = (DW'(diff_reg) >= span);

    assign under_inc = (&under_cnt_reg) ? under_cnt_reg : under_cnt_reg + COUNT_BITS'(1);
    assign over_inc  = (&over_cnt_reg)  ? over_cnt_reg  : over_cnt_reg  + COUNT_BITS'(1);
    assign bin_inc   = (&mem_rdata)     ? mem_rdata     : mem_rdata     + COUNT_BITS'(1);

    always_comb
    begin
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        cell_width_next = cell_width_reg;
        cell_count_next = cell_count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_RANGE_LOW:  range_low_next  = cfg_data;
                CFG_RANGE_HIGH: range_high_next = cfg_data;
                CFG_CELL_WIDTH: cell_width_next = cfg_data[WIDTH_W-1:0];
                CFG_CELL_COUNT: cell_count_next = cfg_data[CCOUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        under_cnt_next  = under_cnt_reg;
        over_cnt_next   = over_cnt_reg;
        op_next         = op_reg;
        sample_next     = sample_reg;
        diff_next       = diff_reg;
        above_next      = above_reg;
        bad_next        = bad_reg;
        idx_next        = idx_reg;
        res_region_next = res_region_reg;
        res_value_next  = res_value_reg;
        out_index_next  = out_index_reg;
        out_region_next = out_region_reg;
        out_value_next  = out_value_reg;
        out_under_next  = out_under_reg;
        out_over_next   = out_over_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        mem_cmd         = '0;
        mem_addr        = idx_reg;
        div_start       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next     = s_tuser;
                    sample_next = s_tdata[SAMPLE_W-1:0];
                    idx_next    = IDX_W'(in_rindex);
                    bad_next    = (int'(in_rindex) >= int'(nbins));
                    if (s_tuser == OP_READ)
                    begin
                        mem_cmd.rd = 1'b1;
                        mem_addr   = IDX_W'(in_rindex);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                if (diff_full[SAMPLE_W])
                begin
                    under_cnt_next  = under_inc;
                    res_region_next = REGION_UNDER;
                    res_value_next  = '0;
                    idx_next        = '0;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    diff_next  = diff_full[SAMPLE_W-1:0];
                    above_next = (sample_reg >= range_high_reg);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (above_reg || big)
                begin
                    over_cnt_next   = over_inc;
                    res_region_next = REGION_OVER;
                    res_value_next  = '0;
                    idx_next        = '0;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if ({1'b0, div_quot} >= nbins)
                    begin
                        over_cnt_next   = over_inc;
                        res_region_next = REGION_OVER;
                        res_value_next  = '0;
                        idx_next        = '0;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        idx_next   = div_quot;
                        mem_cmd.rd = 1'b1;
                        mem_addr   = div_quot;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (op_reg == OP_READ)
                begin
                    if (bad_reg)
                    begin
                        res_region_next = REGION_BAD_READ;
                        res_value_next  = '0;
                        idx_next        = '0;
                    end
                    else
                    begin
                        res_region_next = REGION_IN;
                        res_value_next  = mem_rdata;
                    end
                end
                else
                begin
                    mem_cmd.wr      = 1'b1;
                    res_region_next = REGION_IN;
                    res_value_next  = bin_inc;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = INDEX_W'(idx_reg);
                    out_region_next = res_region_reg;
                    out_value_next  = VALUE_W'(res_value_reg);
                    out_under_next  = VALUE_W'(under_cnt_reg);
                    out_over_next   = VALUE_W'(over_cnt_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            under_cnt_reg  <= '0;
            over_cnt_reg   <= '0;
            range_low_reg  <= RANGE_LOW_RST;
            range_high_reg <= RANGE_HIGH_RST;
            cell_width_reg <= CELL_WIDTH_RST;
            cell_count_reg <= CELL_COUNT_RST;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            under_cnt_reg  <= under_cnt_next;
            over_cnt_reg   <= over_cnt_next;
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            cell_width_reg <= cell_width_next;
            cell_count_reg <= cell_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        sample_reg     <= sample_next;
        diff_reg       <= diff_next;
        above_reg      <= above_next;
        bad_reg        <= bad_next;
        idx_reg        <= idx_next;
        res_region_reg <= res_region_next;
        res_value_reg  <= res_value_next;
        out_index_reg  <= out_index_next;
        out_region_reg <= out_region_next;
        out_value_reg  <= out_value_next;
        out_under_reg  <= out_under_next;
        out_over_reg   <= out_over_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_region_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                       out_over_reg, out_under_reg, out_value_reg, out_index_reg};

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_under_step: assert property (@(posedge clk) disable iff (!rst_n)
        (under_cnt_reg != $past(under_cnt_reg))
            |-> (under_cnt_reg == $past(under_cnt_reg) + COUNT_BITS'(1))
                && ($past(state_reg) == ST_PREP))
        else $error("underflow counter moved other than by one sample");

    a_over_step: assert property (@(posedge clk) disable iff (!rst_n)
        (over_cnt_reg != $past(over_cnt_reg))
            |-> (over_cnt_reg == $past(over_cnt_reg) + COUNT_BITS'(1))
                && (($past(state_reg) == ST_CHECK) || ($past(state_reg) == ST_DIV)))
        else $error("overflow counter moved other than by one sample");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_free) |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("result not loaded into the output register");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !mem_ready |-> !s_tready)
        else $error("input taken during the memory clear sweep");

endmodule

// File: tb/sv/equal_width_histogram_core_test.sv
module equal_width_histogram_core_test;
    import ewh_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE = 24;

    typedef struct {
        logic [INDEX_W-1:0] bin_index;
        region_t            region;
        logic [VALUE_W-1:0] bin_value;
        logic [VALUE_W-1:0] under_total;
        logic [VALUE_W-1:0] over_total;
    } bin_result_t;

    class histogram_tracker;
        logic [REG_W-1:0]    range_low;
        logic [REG_W-1:0]    range_high;
        logic [WIDTH_W-1:0]  cell_width;
        logic [CCOUNT_W-1:0] cell_count;
        logic [VALUE_W-1:0]  bin_counts [DEF_MAX_BINS];
        logic [VALUE_W-1:0]  under_count;
        logic [VALUE_W-1:0]  over_count;
        bin_result_t         pending_results [$];
        int                  errors;

        function new();
            range_low = RANGE_LOW_RST;
            range_high = RANGE_HIGH_RST;
            cell_width = CELL_WIDTH_RST;
            cell_count = CELL_COUNT_RST;
            foreach (bin_counts[i]) bin_counts[i] = '0;
            under_count = '0;
            over_count = '0;
            errors = 0;
        endfunction

        function int bins_in_use();
            return (cell_count > DEF_MAX_BINS) ? DEF_MAX_BINS : int'(cell_count);
        endfunction

        function logic [VALUE_W-1:0] bump(logic [VALUE_W-1:0] c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        function void set_reg(cfg_index_t idx, logic [REG_W-1:0] value);
            case (idx)
                CFG_RANGE_LOW:  range_low = value;
                CFG_RANGE_HIGH: range_high = value;
                CFG_CELL_WIDTH: cell_width = value[WIDTH_W-1:0];
                CFG_CELL_COUNT: cell_count = value[CCOUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void tally_input(logic op, logic [SAMPLE_W-1:0] smp,
                                  logic [INDEX_W-1:0] ridx);
            bin_result_t r;
            longint s, lo, hi, w, k;
            int nbins;
            nbins = bins_in_use();
            r.bin_index = '0;
            r.region = REGION_IN;
            r.bin_value = '0;
            if (op == OP_COLLECT)
            begin
                s = longint'($signed(smp));
                lo = longint'($signed(range_low));
                hi = longint'($signed(range_high));
                w = (cell_width == '0) ? 64'sd1 : longint'(cell_width);
                if (s < lo)
                begin
                    under_count = bump(under_count);
                    r.region = REGION_UNDER;
                end
                else
                begin
                    k = (s - lo) / w;
                    if (k >= nbins || s >= hi)
                    begin
                        over_count = bump(over_count);
                        r.region = REGION_OVER;
                    end
                    else
                    begin
                        bin_counts[k] = bump(bin_counts[k]);
                        r.bin_index = k[INDEX_W-1:0];
                        r.bin_value = bin_counts[k];
                    end
                end
            end
            else
            begin
                if (int'(ridx) >= nbins)
                begin
                    r.region = REGION_BAD_READ;
                end
                else
                begin
                    r.bin_index = ridx;
                    r.bin_value = bin_counts[ridx];
                end
            end
            r.under_total = under_count;
            r.over_total = over_count;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("mismatch on %s at %0t: got %0h, want %0h", what, $time, got, want);
            errors++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] tdata, logic [1:0] tuser);
            bin_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected transfer", tdata[INDEX_W-1:0], 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (tuser != want.region)
                    report_mismatch("region", tuser, want.region);
                if (tdata[9:0] != want.bin_index)
                    report_mismatch("bin_index", tdata[9:0], want.bin_index);
                if (tdata[41:10] != want.bin_value)
                    report_mismatch("bin_value", tdata[41:10], want.bin_value);
                if (tdata[73:42] != want.under_total)
                    report_mismatch("under_total", tdata[73:42], want.under_total);
                if (tdata[105:74] != want.over_total)
                    report_mismatch("over_total", tdata[105:74], want.over_total);
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    cfg_index_t           cfg_index;
    logic [REG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    histogram_tracker tracker = new();
    bit steady;
    int cycles;

    equal_width_histogram_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] to_q16(longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tuser);
    end

    initial
    begin
        int hold;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic push_item(input logic op, input logic [SAMPLE_W-1:0] smp,
                             input logic [INDEX_W-1:0] ridx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'b0, ridx, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.tally_input(op, smp, ridx);
    endtask

    task automatic push_random_item();
        logic op;
        logic [SAMPLE_W-1:0] smp;
        logic [INDEX_W-1:0] ridx;
        int roll, nb;
        longint lo, hi, w, span, k;
        nb = tracker.bins_in_use();
        lo = longint'($signed(tracker.range_low));
        hi = longint'($signed(tracker.range_high));
        w = (tracker.cell_width == '0) ? 64'sd1 : longint'(tracker.cell_width);
        op = ($urandom_range(0, 99) < 25) ? OP_READ : OP_COLLECT;
        smp = $urandom;
        ridx = INDEX_W'($urandom);
        roll = $urandom_range(0, 99);
        if (op == OP_READ)
        begin
            if (roll < 70 && nb > 0)
                ridx = INDEX_W'($urandom_range(0, nb - 1));
            else if (roll < 85)
                ridx = INDEX_W'(($urandom_range(0, 1) == 1 || nb == 0) ? nb : nb - 1);
        end
        else
        begin
            span = nb * w;
            if (hi - lo < span)
                span = hi - lo;
            if (span <= 0)
                span = 1;
            k = longint'($urandom_range(0, nb));
            if (roll < 65)
                smp = to_q16(lo + longint'($urandom) % span);
            else if (roll < 85)
                case ($urandom_range(0, 5))
                    0: smp = to_q16(lo - 1);
                    1: smp = to_q16(lo);
                    2: smp = to_q16(hi - 1);
                    3: smp = to_q16(hi);
                    4: smp = to_q16(lo + k * w);
                    default: smp = to_q16(lo + k * w - 1);
                endcase
        end
        push_item(op, smp, ridx);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [30:0] w, input logic [10:0] n);
        cfg_we <= 1'b1;
        cfg_index <= CFG_RANGE_LOW;
        cfg_data <= lo;
        @(posedge clk);
        tracker.set_reg(CFG_RANGE_LOW, lo);
        cfg_index <= CFG_RANGE_HIGH;
        cfg_data <= hi;
        @(posedge clk);
        tracker.set_reg(CFG_RANGE_HIGH, hi);
        cfg_index <= CFG_CELL_WIDTH;
        cfg_data <= {1'b0, w};
        @(posedge clk);
        tracker.set_reg(CFG_CELL_WIDTH, {1'b0, w});
        cfg_index <= CFG_CELL_COUNT;
        cfg_data <= {21'b0, n};
        @(posedge clk);
        tracker.set_reg(CFG_CELL_COUNT, {21'b0, n});
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [30:0] w, input logic [10:0] n, input int items);
        load_config(lo, hi, w, n);
        steady = ($urandom_range(0, 3) == 0);
        repeat (items) push_random_item();
        drain();
    endtask

    task automatic run_random_phase(input int items);
        logic [31:0] lo, hi;
        logic [30:0] w;
        logic [10:0] n;
        longint top;
        case ($urandom_range(0, 3))
            0: lo = 32'd0;
            1: lo = to_q16(longint'($urandom_range(0, 1 << 21)) - (1 << 20));
            2: lo = $urandom;
            default: lo = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_0000;
        endcase
        n = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                        : 11'($urandom_range(1, 64));
        w = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 18));
        top = longint'($signed(lo)) + longint'(n) * longint'(w);
        case ($urandom_range(0, 6))
            0: hi = $urandom;
            1: hi = 32'h7FFF_FFFF;
            default: hi = to_q16(top - $urandom_range(0, 2) * longint'(w));
        endcase
        run_phase(lo, hi, w, n, items);
    endtask

    initial
    begin
        cycles <= 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_RANGE_LOW;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tuser <= OP_COLLECT;
        s_tdata <= '0;
        steady = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_item(OP_COLLECT, 32'd0, 10'd0);
        push_item(OP_COLLECT, 32'd0, 10'h3FF);
        push_item(OP_COLLECT, 32'h0000_FFFF, 10'd0);
        push_item(OP_COLLECT, 32'd65536, 10'd0);
        push_item(OP_COLLECT, 32'd3276799, 10'd0);
        push_item(OP_COLLECT, 32'd3276800, 10'd0);
        push_item(OP_COLLECT, 32'h7FFF_FFFF, 10'd0);
        push_item(OP_COLLECT, 32'h8000_0000, 10'd0);
        push_item(OP_COLLECT, 32'hFFFF_FFFF, 10'd0);
        push_item(OP_COLLECT, 32'd1000000, 10'd0);
        push_item(OP_READ, 32'hFFFF_FFFF, 10'd0);
        push_item(OP_READ, 32'd0, 10'd1);
        push_item(OP_READ, 32'd0, 10'd49);
        push_item(OP_READ, 32'd0, 10'd50);
        push_item(OP_READ, 32'd0, 10'h3FF);
        push_item(OP_READ, 32'd0, 10'd15);
        push_item(OP_READ, 32'd0, 10'd512);
        repeat (130) push_random_item();
        drain();

        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 11'd2047, 140);
        run_phase(-32'sd655360, 32'd655360, 31'd0, 11'd1024, 140);
        run_phase(-32'sd65536, 32'd6553600, 31'd65536, 11'd0, 140);
        run_phase(32'd327680, -32'sd65536, 31'd32768, 11'd20, 140);
        run_phase(32'd0, 32'h7FFF_FFFF, 31'd1, 11'd1024, 140);
        repeat (7) run_random_phase(140);

        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
